// ===== rtl/mec_pkg.sv =====
// ============================================================================
// mec_pkg
// Shared widths, types and helpers of the escape-time pixel colorer.
// ============================================================================
`default_nettype none

package mec_pkg;

  localparam int FRAC_BITS = 28;
  localparam int W         = 8 + FRAC_BITS;
  localparam int HALF      = W / 2;
  localparam int PPW       = 2 * (HALF + 1);
  localparam int PW        = 2 * W;
  localparam int SQW       = PW - FRAC_BITS;
  localparam int XYW       = SQW + 1;
  localparam int SW        = XYW + 3;

  localparam int MAX_DIM  = 4096;
  localparam int DIM_BITS = $clog2(MAX_DIM);
  localparam int COORD_W  = 12;
  localparam int STEP_W   = 29;
  localparam int ITER_W   = 16;
  localparam int COLOR_W  = 8;
  localparam int CPROD_W  = DIM_BITS + STEP_W;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = W;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REAL_ORIGIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAG_ORIGIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REAL_STEP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAG_STEP   = 3'd4;

  localparam logic [ITER_W-1:0]        RST_MAX_ITER    = 16'd255;
  localparam logic signed [W-1:0]      RST_REAL_ORIGIN = -36'sd536870912;
  localparam logic signed [W-1:0]      RST_IMAG_ORIGIN = -36'sd402653184;
  localparam logic [STEP_W-1:0]        RST_REAL_STEP   = 29'd786432;
  localparam logic [STEP_W-1:0]        RST_IMAG_STEP   = 29'd786432;

  // power of two
  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);

  typedef struct packed {
    logic [COORD_W-1:0]  column;
    logic [COORD_W-1:0]  row;
    logic signed [W-1:0] cx;
    logic signed [W-1:0] cy;
  } mec_item_t;

  typedef struct packed {
    logic [ITER_W-1:0]   max_iterations;
    logic signed [W-1:0] real_origin;
    logic signed [W-1:0] imag_origin;
    logic [STEP_W-1:0]   real_step;
    logic [STEP_W-1:0]   imag_step;
  } mec_cfg_t;

  function automatic logic signed [W-1:0] sat_w(input logic signed [SW-1:0] v);
    logic signed [W-1:0] res;
    if ((&v[SW-1:W-1]) || !(|v[SW-1:W-1])) begin
      res = v[W-1:0];
    end else if (v[SW-1]) begin
      res = {1'b1, {(W-1){1'b0}}};
    end else begin
      res = {1'b0, {(W-1){1'b1}}};
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/mandelbrot_escape_coloring.sv =====
// ============================================================================
// mandelbrot_escape_coloring
// Escape-time colorer: one pixel index in, one colored pixel out.
//
// Write max_iterations, origins and steps through cfg_we/cfg_index/cfg_wdata
// while no pixel is in flight. A pixel (in_column, in_row) is taken when
// in_valid is high and in_stall is low; the result (out_column, out_row,
// out_red, out_green) leaves when out_valid is high and out_stall is low.
// The front stage registers the step products, adds the origin to form c
// and parks c in a two-entry FIFO, so it keeps taking pixels while the core
// iterates. The core runs each iteration of z = z^2 + c as a partial-product
// step, a sum step and an escape-test-and-update step, and a pixel holds the
// core for n passes through these steps, n being the escape tests made
// (iterations done, plus one if the pixel escapes; at most max_iterations,
// 255 after reset). A finished pixel waits in the output register while
// out_stall is high; the core then holds in its finish step and the FIFO
// and front fill up before in_stall rises. Reset empties all stages and
// restores the register defaults (limit 255, origin -2.0 - 1.5i, steps
// 3/1024).
// ============================================================================
`default_nettype none

module mandelbrot_escape_coloring (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [mec_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mec_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [mec_pkg::COORD_W-1:0]       in_column,
  input  logic [mec_pkg::COORD_W-1:0]       in_row,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [mec_pkg::COORD_W-1:0]       out_column,
  output logic [mec_pkg::COORD_W-1:0]       out_row,
  output logic [mec_pkg::COLOR_W-1:0]       out_red,
  output logic [mec_pkg::COLOR_W-1:0]       out_green
);
  import mec_pkg::*;

  mec_cfg_t   cfg_r, cfg_nxt;
  logic       push_valid, push_ready, pop_valid, pop_ready;
  mec_item_t  push_item, pop_item;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX_ITER:    cfg_nxt.max_iterations = cfg_wdata[ITER_W-1:0];
        CFG_REAL_ORIGIN: cfg_nxt.real_origin    = $signed(cfg_wdata[W-1:0]);
        CFG_IMAG_ORIGIN: cfg_nxt.imag_origin    = $signed(cfg_wdata[W-1:0]);
        CFG_REAL_STEP:   cfg_nxt.real_step      = cfg_wdata[STEP_W-1:0];
        CFG_IMAG_STEP:   cfg_nxt.imag_step      = cfg_wdata[STEP_W-1:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_iterations <= RST_MAX_ITER;
      cfg_r.real_origin    <= RST_REAL_ORIGIN;
      cfg_r.imag_origin    <= RST_IMAG_ORIGIN;
      cfg_r.real_step      <= RST_REAL_STEP;
      cfg_r.imag_step      <= RST_IMAG_STEP;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  mec_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_column  (in_column),
    .in_row     (in_row),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  mec_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  mec_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .max_iterations (cfg_r.max_iterations),
    .pop_valid      (pop_valid),
    .pop_ready      (pop_ready),
    .pop_item       (pop_item),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_column     (out_column),
    .out_row        (out_row),
    .out_red        (out_red),
    .out_green      (out_green)
  );

endmodule

`default_nettype wire

// ===== rtl/mec_front.sv =====
// ============================================================================
// mec_front
// Accepts pixels, registers index times step and adds the origin to form c.
// ============================================================================
`default_nettype none

module mec_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  mec_pkg::mec_cfg_t               cfg,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [mec_pkg::COORD_W-1:0]     in_column,
  input  logic [mec_pkg::COORD_W-1:0]     in_row,
  output logic                            push_valid,
  input  logic                            push_ready,
  output mec_pkg::mec_item_t              push_item
);
  import mec_pkg::*;

  logic                s1_valid_r, s1_valid_nxt;
  logic [COORD_W-1:0]  s1_col_r, s1_row_r;
  logic [CPROD_W-1:0]  s1_rprod_r, s1_iprod_r;
  logic                in_take;

  assign in_stall   = s1_valid_r && !push_ready;
  assign in_take    = in_valid && !in_stall;
  assign push_valid = s1_valid_r;

  always_comb begin
    s1_valid_nxt = in_take || (s1_valid_r && !push_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_col_r   <= in_column;
      s1_row_r   <= in_row;
      s1_rprod_r <= CPROD_W'(in_column[DIM_BITS-1:0]) * CPROD_W'(cfg.real_step);
      s1_iprod_r <= CPROD_W'(in_row[DIM_BITS-1:0]) * CPROD_W'(cfg.imag_step);
    end
  end

  always_comb begin
    push_item.column = s1_col_r;
    push_item.row    = s1_row_r;
    push_item.cx     = sat_w(SW'(cfg.real_origin) + SW'($signed({1'b0, s1_rprod_r})));
    push_item.cy     = sat_w(SW'(cfg.imag_origin) + SW'($signed({1'b0, s1_iprod_r})));
  end

endmodule

`default_nettype wire

// ===== rtl/mec_queue.sv =====
// ============================================================================
// mec_queue
// Short FIFO of prepared pixels between the front and the iteration core.
// ============================================================================
`default_nettype none

module mec_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_valid,
  output logic                 push_ready,
  input  mec_pkg::mec_item_t   push_item,
  output logic                 pop_valid,
  input  logic                 pop_ready,
  output mec_pkg::mec_item_t   pop_item
);
  import mec_pkg::*;

  mec_item_t        mem_r [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QAW:0]     cnt_r, cnt_nxt;
  logic             push, pop;

  assign push_ready = (cnt_r != (QAW+1)'(QDEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mec_core.sv =====
// ============================================================================
// mec_core
// Iterates z = z^2 + c in three steps per iteration and colors the pixel.
// ============================================================================
`default_nettype none

module mec_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [mec_pkg::ITER_W-1:0]    max_iterations,
  input  logic                          pop_valid,
  output logic                          pop_ready,
  input  mec_pkg::mec_item_t            pop_item,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [mec_pkg::COORD_W-1:0]   out_column,
  output logic [mec_pkg::COORD_W-1:0]   out_row,
  output logic [mec_pkg::COLOR_W-1:0]   out_red,
  output logic [mec_pkg::COLOR_W-1:0]   out_green
);
  import mec_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_SUM  = 3'd2;
  localparam logic [2:0] ST_UPD  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  localparam logic signed [SQW:0] FOUR        = (SQW+1)'(4) <<< FRAC_BITS;
  localparam int                  COLOR_SCALE = 10;

  function automatic logic signed [PPW-1:0] pmul(input logic signed [HALF:0] a,
                                                 input logic signed [HALF:0] b);
    return PPW'(a) * PPW'(b);
  endfunction

  function automatic logic [COLOR_W-1:0] color_of(input logic signed [W:0] d);
    logic [W:0]           mag;
    logic [COLOR_W-1:0]   ipl;
    logic [COLOR_W+3:0]   prod;
    mag  = d[W] ? (W+1)'(-d) : (W+1)'(d);
    ipl  = mag[FRAC_BITS+COLOR_W-1:FRAC_BITS];
    if (d[W]) begin
      ipl = -ipl;
    end
    prod = (COLOR_W+4)'(ipl) * (COLOR_W+4)'(COLOR_SCALE);
    return prod[COLOR_W-1:0];
  endfunction

  logic [2:0]               state_r, state_nxt;
  logic [ITER_W-1:0]        cnt_r, cnt_nxt, cnt_inc;
  logic signed [W-1:0]      zx_r, zy_r, zx_nxt, zy_nxt;
  logic signed [W-1:0]      cx_r, cy_r;
  logic [COORD_W-1:0]       col_r, row_r;

  logic signed [PPW-1:0]    xx_hh_r, xx_hl_r, xx_ll_r;
  logic signed [PPW-1:0]    yy_hh_r, yy_hl_r, yy_ll_r;
  logic signed [PPW-1:0]    xy_hh_r, xy_hl_r, xy_lh_r, xy_ll_r;
  logic signed [SQW-1:0]    sqx_r, sqy_r;
  logic signed [XYW-1:0]    xy_r;

  logic signed [HALF:0]     xh, xl, yh, yl;
  logic signed [PW-1:0]     px, py, pxy;
  logic signed [SQW:0]      mag2;
  logic                     escape;
  logic signed [W-1:0]      nx, ny;

  logic                     out_valid_r, out_valid_nxt, out_load;
  logic [COORD_W-1:0]       out_col_r, out_row_r;
  logic [COLOR_W-1:0]       out_red_r, out_green_r;

  assign pop_ready  = (state_r == ST_IDLE);
  assign out_load   = (state_r == ST_FIN) && (!out_valid_r || !out_stall);
  assign out_valid  = out_valid_r;
  assign out_column = out_col_r;
  assign out_row    = out_row_r;
  assign out_red    = out_red_r;
  assign out_green  = out_green_r;

  always_comb begin
    xh = (HALF+1)'($signed(zx_r[W-1:HALF]));
    xl = $signed({1'b0, zx_r[HALF-1:0]});
    yh = (HALF+1)'($signed(zy_r[W-1:HALF]));
    yl = $signed({1'b0, zy_r[HALF-1:0]});

    px  = (PW'(xx_hh_r) <<< (2*HALF)) + (PW'(xx_hl_r) <<< (HALF+1)) + PW'(xx_ll_r);
    py  = (PW'(yy_hh_r) <<< (2*HALF)) + (PW'(yy_hl_r) <<< (HALF+1)) + PW'(yy_ll_r);
    pxy = (PW'(xy_hh_r) <<< (2*HALF)) + ((PW'(xy_hl_r) + PW'(xy_lh_r)) <<< HALF)
        + PW'(xy_ll_r);

    mag2    = (SQW+1)'(sqx_r) + (SQW+1)'(sqy_r);
    escape  = (mag2 > FOUR);
    nx      = sat_w(SW'(sqx_r) - SW'(sqy_r) + SW'(cx_r));
    ny      = sat_w(SW'(xy_r) + SW'(cy_r));
    cnt_inc = cnt_r + 1'b1;
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    zx_nxt    = zx_r;
    zy_nxt    = zy_r;
    unique case (state_r)
      ST_IDLE: begin
        if (pop_valid) begin
          cnt_nxt   = '0;
          zx_nxt    = '0;
          zy_nxt    = '0;
          state_nxt = (max_iterations == '0) ? ST_FIN : ST_MUL;
        end
      end
      ST_MUL: begin
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        if (escape) begin
          state_nxt = ST_FIN;
        end else begin
          zx_nxt    = nx;
          zy_nxt    = ny;
          cnt_nxt   = cnt_inc;
          state_nxt = (cnt_inc == max_iterations) ? ST_FIN : ST_MUL;
        end
      end
      ST_FIN: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_load || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    zx_r  <= zx_nxt;
    zy_r  <= zy_nxt;
    if (pop_valid && pop_ready) begin
      cx_r  <= pop_item.cx;
      cy_r  <= pop_item.cy;
      col_r <= pop_item.column;
      row_r <= pop_item.row;
    end
    if (state_r == ST_MUL) begin
      xx_hh_r <= pmul(xh, xh);
      xx_hl_r <= pmul(xh, xl);
      xx_ll_r <= pmul(xl, xl);
      yy_hh_r <= pmul(yh, yh);
      yy_hl_r <= pmul(yh, yl);
      yy_ll_r <= pmul(yl, yl);
      xy_hh_r <= pmul(xh, yh);
      xy_hl_r <= pmul(xh, yl);
      xy_lh_r <= pmul(xl, yh);
      xy_ll_r <= pmul(xl, yl);
    end
    if (state_r == ST_SUM) begin
      sqx_r <= SQW'(px >>> FRAC_BITS);
      sqy_r <= SQW'(py >>> FRAC_BITS);
      xy_r  <= XYW'(pxy >>> (FRAC_BITS - 1));
    end
    if (out_load) begin
      out_col_r   <= col_r;
      out_row_r   <= row_r;
      out_red_r   <= color_of((W+1)'(zx_r) - (W+1)'(cx_r));
      out_green_r <= color_of((W+1)'(zy_r) - (W+1)'(cy_r));
    end
  end

endmodule

`default_nettype wire

// ===== verif/mandelbrot_escape_coloring_test.sv =====
// ============================================================================
// mandelbrot_escape_coloring_test
// Self-checking bench for the escape-time pixel colorer. Pixel coordinates
// are pushed under a series of register setups: reset values, extreme limits
// and origins, zero and full-scale steps, then randomized windows. An
// independent fixed-point iteration predicts every colored pixel, and each
// returned transaction is compared field by field, in order.
// ============================================================================
module mandelbrot_escape_coloring_test;
  timeunit 1ns;
  timeprecision 1ps;
  import mec_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_HI = 3'd7;
  localparam longint Q_ONE = 64'sd1 <<< FRAC_BITS;
  localparam longint Q_MAX = (64'sd1 <<< (W - 1)) - 1;
  localparam longint Q_MIN = -(64'sd1 <<< (W - 1));
  localparam int RANDOM_SETUPS    = 13;
  localparam int PIXELS_PER_SETUP = 100;
  localparam int SETTLE_CYCLES    = 40;
  localparam int MAX_REPORTS      = 100;

  typedef struct {
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] row;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
  } pixel_t;

  class pixel_scoreboard;
    logic [ITER_W-1:0] iter_limit;
    longint            re_origin;
    longint            im_origin;
    logic [STEP_W-1:0] re_step;
    logic [STEP_W-1:0] im_step;
    pixel_t            colored_q[$];
    int                mismatches;
    int                pixels_noted;
    int                pixels_checked;

    function new();
      iter_limit     = RST_MAX_ITER;
      re_origin      = RST_REAL_ORIGIN;
      im_origin      = RST_IMAG_ORIGIN;
      re_step        = RST_REAL_STEP;
      im_step        = RST_IMAG_STEP;
      mismatches     = 0;
      pixels_noted   = 0;
      pixels_checked = 0;
    endfunction

    function void store_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_MAX_ITER:    iter_limit = data[ITER_W-1:0];
        CFG_REAL_ORIGIN: re_origin  = signed'(data);
        CFG_IMAG_ORIGIN: im_origin  = signed'(data);
        CFG_REAL_STEP:   re_step    = data[STEP_W-1:0];
        CFG_IMAG_STEP:   im_step    = data[STEP_W-1:0];
        default: ;
      endcase
    endfunction

    function longint clamp_q(longint v);
      if (v > Q_MAX) return Q_MAX;
      if (v < Q_MIN) return Q_MIN;
      return v;
    endfunction

    function longint scaled_product(longint a, longint b, int shift);
      logic signed [79:0] pa;
      logic signed [79:0] pb;
      logic signed [79:0] p;
      pa = a;
      pb = b;
      p  = (pa * pb) >>> shift;
      return p[63:0];
    endfunction

    function logic [COLOR_W-1:0] shade(longint d);
      longint     whole;
      logic [63:0] t;
      whole = (d >= 0) ? (d >>> FRAC_BITS) : -((-d) >>> FRAC_BITS);
      t     = whole * 10;
      return t[COLOR_W-1:0];
    endfunction

    function void note_pixel(logic [COORD_W-1:0] col, logic [COORD_W-1:0] row);
      longint colv, rowv, sx, sy, cx, cy, zx, zy, zx2, zy2, nzy;
      pixel_t px;
      colv = col;
      rowv = row;
      sx   = re_step;
      sy   = im_step;
      cx   = clamp_q(re_origin + colv * sx);
      cy   = clamp_q(im_origin + rowv * sy);
      zx   = 0;
      zy   = 0;
      for (int unsigned n = 0; n < iter_limit; n++) begin
        zx2 = scaled_product(zx, zx, FRAC_BITS);
        zy2 = scaled_product(zy, zy, FRAC_BITS);
        if (zx2 + zy2 > 4 * Q_ONE) break;
        nzy = clamp_q(scaled_product(zx, zy, FRAC_BITS - 1) + cy);
        zx  = clamp_q(zx2 - zy2 + cx);
        zy  = nzy;
      end
      px.column = col;
      px.row    = row;
      px.red    = shade(zx - cx);
      px.green  = shade(zy - cy);
      colored_q.push_back(px);
      pixels_noted++;
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    task check_pixel(logic [COORD_W-1:0] col, logic [COORD_W-1:0] row,
                     logic [COLOR_W-1:0] red, logic [COLOR_W-1:0] green);
      pixel_t want;
      if (colored_q.size() == 0) begin
        report_mismatch($sformatf("unexpected pixel (%0d,%0d)", col, row));
        return;
      end
      want = colored_q.pop_front();
      pixels_checked++;
      if (col !== want.column)
        report_mismatch($sformatf("column got %0d want %0d", col, want.column));
      if (row !== want.row)
        report_mismatch($sformatf("row got %0d want %0d", row, want.row));
      if (red !== want.red)
        report_mismatch($sformatf("red of (%0d,%0d) got %0d want %0d",
                                  want.column, want.row, red, want.red));
      if (green !== want.green)
        report_mismatch($sformatf("green of (%0d,%0d) got %0d want %0d",
                                  want.column, want.row, green, want.green));
    endtask
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_stall;
  logic [COORD_W-1:0]    in_column;
  logic [COORD_W-1:0]    in_row;
  logic                  out_valid;
  logic                  out_stall;
  logic [COORD_W-1:0]    out_column;
  logic [COORD_W-1:0]    out_row;
  logic [COLOR_W-1:0]    out_red;
  logic [COLOR_W-1:0]    out_green;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int setups        = 0;
  pixel_scoreboard board;

  mandelbrot_escape_coloring uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_column  (in_column),
    .in_row     (in_row),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_column (out_column),
    .out_row    (out_row),
    .out_red    (out_red),
    .out_green  (out_green)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #200_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_pixel(out_column, out_row, out_red, out_green);
  end

  task automatic send_pixel(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid  <= 1'b0;
      in_column <= COORD_W'($urandom);
      in_row    <= COORD_W'($urandom);
    end
    @(negedge clk);
    in_valid  <= 1'b1;
    in_column <= col;
    in_row    <= row;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_pixel(col, row);
  endtask

  task automatic drain_pixels();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.colored_q.size() != 0) @(posedge clk);
  endtask

  task automatic drive_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    board.store_register(idx, data);
  endtask

  // unmapped write goes last so an aliasing decode would corrupt the setup
  task automatic apply_setup(input logic [ITER_W-1:0] iters, input longint rorg,
                             input longint iorg, input logic [STEP_W-1:0] rstep,
                             input logic [STEP_W-1:0] istep);
    logic [CFG_DATA_W-1:0] data;
    data = CFG_DATA_W'({$urandom, $urandom});
    data[ITER_W-1:0] = iters;
    drive_register(CFG_MAX_ITER, data);
    drive_register(CFG_REAL_ORIGIN, rorg[CFG_DATA_W-1:0]);
    drive_register(CFG_IMAG_ORIGIN, iorg[CFG_DATA_W-1:0]);
    data = CFG_DATA_W'({$urandom, $urandom});
    data[STEP_W-1:0] = rstep;
    drive_register(CFG_REAL_STEP, data);
    data = CFG_DATA_W'({$urandom, $urandom});
    data[STEP_W-1:0] = istep;
    drive_register(CFG_IMAG_STEP, data);
    drive_register(CFG_IDX_W'($urandom_range(CFG_UNMAPPED_LO, CFG_UNMAPPED_HI)),
                   CFG_DATA_W'({$urandom, $urandom}));
    @(negedge clk);
    cfg_we <= 1'b0;
    setups++;
  endtask

  task automatic random_setup();
    int                  pick;
    logic [ITER_W-1:0]   iters;
    logic signed [W-1:0] raw;
    longint              rorg, iorg;
    logic [STEP_W-1:0]   rstep, istep;
    pick = $urandom_range(9);
    if (pick == 0) iters = '0;
    else if (pick <= 6) iters = ITER_W'($urandom_range(1, 24));
    else if (pick <= 8) iters = ITER_W'($urandom_range(25, 80));
    else iters = ITER_W'($urandom_range(81, 160));
    pick = $urandom_range(9);
    if (pick <= 6) begin
      rorg  = -5 * (Q_ONE / 2) + longint'($urandom_range(0, 32'(3 * Q_ONE / 2)));
      iorg  = -3 * (Q_ONE / 2) + longint'($urandom_range(0, 32'(Q_ONE)));
      rstep = STEP_W'($urandom_range(98304, 262144));
      istep = STEP_W'($urandom_range(98304, 262144));
    end else if (pick <= 8) begin
      raw   = W'({$urandom, $urandom});
      rorg  = raw;
      raw   = W'({$urandom, $urandom});
      iorg  = raw;
      rstep = STEP_W'($urandom);
      istep = STEP_W'($urandom);
    end else begin
      rorg  = -2 * Q_ONE + longint'($urandom_range(0, 32'(Q_ONE)));
      iorg  = -2 * Q_ONE + longint'($urandom_range(0, 32'(Q_ONE)));
      rstep = '1;
      istep = STEP_W'(Q_ONE);
    end
    apply_setup(iters, rorg, iorg, rstep, istep);
  endtask

  initial begin : stimulus
    board     = new();
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    in_column = '0;
    in_row    = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 17;
    recv_idle_pct = 76;

    // reset values; column 0, row 512 sits exactly on |z|^2 = 4
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd0, 12'd512);
    send_pixel(12'd682, 12'd512);
    send_pixel(12'd4095, 12'd4095);
    drain_pixels();

    // zero limit: colors come from -c
    apply_setup('0, RST_REAL_ORIGIN, RST_IMAG_ORIGIN, RST_REAL_STEP, RST_IMAG_STEP);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd2730, 12'd3071);
    drain_pixels();

    // saturated coordinates, largest limit
    apply_setup('1, Q_MAX, Q_MIN, '1, '1);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd4095, 12'd0);
    send_pixel(12'd0, 12'd2048);
    drain_pixels();

    // zero real step, negative differences wrap
    apply_setup(16'd2, Q_ONE, -Q_ONE, '0, STEP_W'(Q_ONE / 2));
    send_pixel(12'd3, 12'd0);
    send_pixel(12'd4095, 12'd2);
    send_pixel(12'd0, 12'd4095);
    drain_pixels();

    apply_setup('1, Q_ONE, -Q_ONE / 4, STEP_W'(Q_ONE / 4), STEP_W'(Q_ONE / 4));
    send_pixel(12'd0, 12'd1);
    send_pixel(12'd2, 12'd3);
    send_pixel(12'd1, 12'd1);
    drain_pixels();

    for (int s = 0; s < RANDOM_SETUPS; s++) begin
      if (s < 5) begin
        send_idle_pct = 17;
        recv_idle_pct = 76;
      end else if (s < 10) begin
        send_idle_pct = 76;
        recv_idle_pct = 17;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      random_setup();
      repeat (PIXELS_PER_SETUP) send_pixel(COORD_W'($urandom), COORD_W'($urandom));
      drain_pixels();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Checked %0d of %0d pixels over %0d register setups (limits 0..65535,",
             board.pixels_checked, board.pixels_noted, setups);
    $display("saturated coordinates, unmapped writes, sender gaps and result stalls).");
    if (board.mismatches == 0 && board.colored_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/mec_pkg.sv
rtl/mec_front.sv
rtl/mec_queue.sv
rtl/mec_core.sv
rtl/mandelbrot_escape_coloring.sv
verif/mandelbrot_escape_coloring_test.sv
